/* design/posl_pkg.sv */
// Package for the positional ordered list: widths, sizes, command and status codes,
// and the queued command record shared by the front end, the queue and the back end.
// Depends on nothing.
`default_nettype none

package posl_pkg;

    localparam int CAPACITY = 16;
    localparam int VAL_W    = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int FLD_CNT_W = 5;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int Q_DEPTH  = 2;
    localparam int QPTR_W   = $clog2(Q_DEPTH);
    localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_LIST      = 3'd6,
        OP_COUNT     = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_POS   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        K_INSERT = 2'd0,
        K_DELETE = 2'd1,
        K_LIST   = 2'd2,
        K_COUNT  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        W_FRONT = 2'd0,
        W_BACK  = 2'd1,
        W_AT    = 2'd2
    } where_t;

    typedef struct packed {
        kind_t             kind;
        where_t            where;
        logic [VAL_W-1:0]  value;
        logic [POS_W-1:0]  position;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_LIST = 1'b1
    } bk_state_t;

endpackage

`default_nettype wire

/* design/posl_front.sv */
// Front end of the positional ordered list: takes commands and sorts them into
// a kind (insert, delete, list, count) and a place (front, back, position).
// Depends on posl_pkg.
`default_nettype none

module posl_front (
    input  wire logic                         start,
    input  wire logic                         q_full,
    input  wire logic [posl_pkg::OP_W-1:0]    opcode,
    input  wire logic signed [posl_pkg::VAL_W-1:0] value,
    input  wire logic [posl_pkg::POS_W-1:0]   position,
    output logic                              busy,
    output logic                              push,
    output posl_pkg::cmd_t                    cmd
);

    posl_pkg::op_t op;

    assign op   = posl_pkg::op_t'(opcode);
    assign busy = q_full;
    assign push = start && !q_full;

    always_comb
    begin
        cmd.value    = value;
        cmd.position = position;
        cmd.kind     = posl_pkg::K_COUNT;
        cmd.where    = posl_pkg::W_FRONT;
        unique case (op)
            posl_pkg::OP_INS_FRONT:
            begin
                cmd.kind  = posl_pkg::K_INSERT;
                cmd.where = posl_pkg::W_FRONT;
            end
            posl_pkg::OP_INS_BACK:
            begin
                cmd.kind  = posl_pkg::K_INSERT;
                cmd.where = posl_pkg::W_BACK;
            end
            posl_pkg::OP_INS_AT:
            begin
                cmd.kind  = posl_pkg::K_INSERT;
                cmd.where = posl_pkg::W_AT;
            end
            posl_pkg::OP_DEL_FRONT:
            begin
                cmd.kind  = posl_pkg::K_DELETE;
                cmd.where = posl_pkg::W_FRONT;
            end
            posl_pkg::OP_DEL_BACK:
            begin
                cmd.kind  = posl_pkg::K_DELETE;
                cmd.where = posl_pkg::W_BACK;
            end
            posl_pkg::OP_DEL_AT:
            begin
                cmd.kind  = posl_pkg::K_DELETE;
                cmd.where = posl_pkg::W_AT;
            end
            posl_pkg::OP_LIST:
            begin
                cmd.kind = posl_pkg::K_LIST;
            end
            posl_pkg::OP_COUNT:
            begin
                cmd.kind = posl_pkg::K_COUNT;
            end
            default:
            begin
                cmd.kind = posl_pkg::K_COUNT;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/posl_queue.sv */
// Short command queue between the front end and the back end of the list.
// Depends on posl_pkg.
`default_nettype none

module posl_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire posl_pkg::cmd_t   push_cmd,
    input  wire logic             pop,
    output posl_pkg::cmd_t        head,
    output posl_pkg::q_status_t   q_stat
);

    posl_pkg::cmd_t                   slots_reg [posl_pkg::Q_DEPTH];
    logic [posl_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [posl_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [posl_pkg::QCNT_W-1:0]      fill_reg, fill_next;
    logic                             do_push, do_pop;

    assign q_stat.empty = (fill_reg == '0);
    assign q_stat.full  = (fill_reg == posl_pkg::QCNT_W'(posl_pkg::Q_DEPTH));
    assign head         = slots_reg[rd_ptr_reg];
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == posl_pkg::QPTR_W'(posl_pkg::Q_DEPTH - 1))
                        ? '0 : wr_ptr_reg + posl_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == posl_pkg::QPTR_W'(posl_pkg::Q_DEPTH - 1))
                        ? '0 : rd_ptr_reg + posl_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + posl_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - posl_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* design/posl_back.sv */
// Back end of the positional ordered list: the shifting value store, the count,
// the checks on each command and the registered result ports.
// Depends on posl_pkg.
`default_nettype none

module posl_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire posl_pkg::cmd_t                head,
    input  wire posl_pkg::q_status_t           q_stat,
    output logic                               pop,
    output logic                               valid,
    output logic signed [posl_pkg::VAL_W-1:0]  value_out,
    output logic [posl_pkg::FLD_CNT_W-1:0]     index_out,
    output logic [posl_pkg::FLD_CNT_W-1:0]     count,
    output logic [1:0]                         status,
    output logic                               last
);

    localparam int CAP = posl_pkg::CAPACITY;

    posl_pkg::bk_state_t                 state_reg, state_next;
    logic [posl_pkg::VAL_W-1:0]          entries_reg [CAP];
    logic [posl_pkg::VAL_W-1:0]          entries_next [CAP];
    logic [posl_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    logic [posl_pkg::IDX_W-1:0]          list_idx_reg, list_idx_next;

    logic                                valid_reg, valid_next;
    logic [posl_pkg::VAL_W-1:0]          value_reg, value_next;
    logic [posl_pkg::FLD_CNT_W-1:0]      index_reg, index_next;
    logic [posl_pkg::FLD_CNT_W-1:0]      count_reg, count_next;
    posl_pkg::status_t                   status_reg, status_next;
    logic                                last_reg, last_next;

    logic                                do_ins, do_del;
    logic [posl_pkg::IDX_W-1:0]          slot;
    logic [posl_pkg::CMP_W-1:0]          pos_ext, cnt_ext;
    logic                                is_full, is_empty, list_end;

    assign pos_ext  = posl_pkg::CMP_W'(head.position);
    assign cnt_ext  = posl_pkg::CMP_W'(cnt_reg);
    assign is_full  = (cnt_reg == posl_pkg::CNT_W'(CAP));
    assign is_empty = (cnt_reg == '0);
    assign list_end = (list_idx_reg == posl_pkg::IDX_W'(cnt_reg - posl_pkg::CNT_W'(1)));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            posl_pkg::BK_IDLE:
            begin
                if (!q_stat.empty && head.kind == posl_pkg::K_LIST && !is_empty)
                begin
                    state_next = posl_pkg::BK_LIST;
                end
            end
            posl_pkg::BK_LIST:
            begin
                if (list_end)
                begin
                    state_next = posl_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = posl_pkg::BK_IDLE;
            end
        endcase
    end

    // Command checks, result fields and store control.
    always_comb
    begin
        pop           = 1'b0;
        do_ins        = 1'b0;
        do_del        = 1'b0;
        slot          = '0;
        list_idx_next = list_idx_reg;
        valid_next    = 1'b0;
        value_next    = '0;
        index_next    = '0;
        status_next   = posl_pkg::ST_OK;
        last_next     = 1'b1;
        unique case (state_reg)
            posl_pkg::BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop        = 1'b1;
                    valid_next = 1'b1;
                    unique case (head.kind)
                        posl_pkg::K_INSERT:
                        begin
                            priority if (is_full)
                            begin
                                status_next = posl_pkg::ST_FULL;
                            end
                            else if (head.where == posl_pkg::W_FRONT)
                            begin
                                do_ins = 1'b1;
                            end
                            else if (head.where == posl_pkg::W_BACK)
                            begin
                                do_ins = 1'b1;
                                slot   = posl_pkg::IDX_W'(cnt_reg);
                            end
                            else if (pos_ext == '0
                                     || pos_ext > cnt_ext + posl_pkg::CMP_W'(1))
                            begin
                                status_next = posl_pkg::ST_POS;
                            end
                            else
                            begin
                                do_ins = 1'b1;
                                slot   = posl_pkg::IDX_W'(pos_ext - posl_pkg::CMP_W'(1));
                            end
                        end
                        posl_pkg::K_DELETE:
                        begin
                            priority if (is_empty)
                            begin
                                status_next = posl_pkg::ST_EMPTY;
                            end
                            else if (head.where == posl_pkg::W_FRONT)
                            begin
                                do_del = 1'b1;
                            end
                            else if (head.where == posl_pkg::W_BACK)
                            begin
                                do_del = 1'b1;
                                slot   = posl_pkg::IDX_W'(cnt_reg - posl_pkg::CNT_W'(1));
                            end
                            else if (pos_ext == '0 || pos_ext > cnt_ext)
                            begin
                                status_next = posl_pkg::ST_POS;
                            end
                            else
                            begin
                                do_del = 1'b1;
                                slot   = posl_pkg::IDX_W'(pos_ext - posl_pkg::CMP_W'(1));
                            end
                        end
                        posl_pkg::K_LIST:
                        begin
                            // A non-empty list is walked from the next cycle on.
                            if (is_empty)
                            begin
                                status_next = posl_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                valid_next    = 1'b0;
                                list_idx_next = '0;
                            end
                        end
                        posl_pkg::K_COUNT:
                        begin
                            status_next = posl_pkg::ST_OK;
                        end
                        default:
                        begin
                            status_next = posl_pkg::ST_OK;
                        end
                    endcase
                end
            end
            posl_pkg::BK_LIST:
            begin
                valid_next    = 1'b1;
                value_next    = entries_reg[list_idx_reg];
                index_next    = posl_pkg::FLD_CNT_W'(posl_pkg::CNT_W'(list_idx_reg)
                                                    + posl_pkg::CNT_W'(1));
                last_next     = list_end;
                list_idx_next = list_idx_reg + posl_pkg::IDX_W'(1);
            end
            default:
            begin
                valid_next = 1'b0;
            end
        endcase

        cnt_next = cnt_reg;
        if (do_ins)
        begin
            cnt_next = cnt_reg + posl_pkg::CNT_W'(1);
        end
        else if (do_del)
        begin
            cnt_next = cnt_reg - posl_pkg::CNT_W'(1);
        end
        count_next = posl_pkg::FLD_CNT_W'(cnt_next);
    end

    // Each store slot picks its own value: hold, take the new word, or take a neighbor.
    always_comb
    begin
        for (int i = 0; i < CAP; i++)
        begin
            entries_next[i] = entries_reg[i];
            if (do_ins)
            begin
                if (posl_pkg::IDX_W'(i) == slot)
                begin
                    entries_next[i] = head.value;
                end
                else if (i > 0 && posl_pkg::IDX_W'(i) > slot)
                begin
                    entries_next[i] = entries_reg[(i > 0) ? i - 1 : 0];
                end
            end
            else if (do_del && i < CAP - 1 && posl_pkg::IDX_W'(i) >= slot)
            begin
                entries_next[i] = entries_reg[(i < CAP - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= posl_pkg::BK_IDLE;
            cnt_reg      <= '0;
            list_idx_reg <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            list_idx_reg <= list_idx_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        index_reg  <= index_next;
        count_reg  <= count_next;
        status_reg <= status_next;
        last_reg   <= last_next;
        for (int i = 0; i < CAP; i++)
        begin
            entries_reg[i] <= entries_next[i];
        end
    end

    assign valid     = valid_reg;
    assign value_out = value_reg;
    assign index_out = index_reg;
    assign count     = count_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= posl_pkg::CNT_W'(CAP))
        else $error("stored count exceeds capacity");

    a_no_pop_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == posl_pkg::BK_LIST |-> !pop)
        else $error("command taken from queue while a list is being walked");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from an empty queue");

    a_list_runs_on: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !last_reg |=> valid_reg)
        else $error("list results not delivered back to back");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && status_reg != posl_pkg::ST_OK |-> last_reg && index_reg == '0)
        else $error("error result not a single final word");

endmodule

`default_nettype wire

/* design/positional_ordered_list.sv */
// Top level of the positional ordered list: front end, command queue and back end.
// Depends on posl_pkg, posl_front, posl_queue and posl_back.
//
// Usage: a command word (opcode, value, position) is taken at a rising edge where
// start is high and busy is low. busy rises only when the two-entry command queue
// is full. Every command gives result words on value_out, index_out, count, status
// and last, each shown for exactly one cycle with valid high; the receiver cannot
// stall, so results are never held back.
// A command reaches the back end from the head of the queue when the back end is
// idle; an edit or count then gives a single registered result, while a list
// command on a non-empty store gives one word per stored value, one per cycle.
// Throughput: an edit or count does not keep the back end from taking the next
// command (the shifting store moves every slot in parallel); a list holds the back
// end while it walks the stored values, and further commands wait in the queue.
// Reset empties the list and the queue and clears valid; stored values are not
// cleared, since only slots below the count are ever read.
`default_nettype none

module positional_ordered_list (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [posl_pkg::OP_W-1:0]     opcode,
    input  wire logic signed [posl_pkg::VAL_W-1:0] value,
    input  wire logic [posl_pkg::POS_W-1:0]    position,
    output logic                               valid,
    output logic signed [posl_pkg::VAL_W-1:0]  value_out,
    output logic [posl_pkg::FLD_CNT_W-1:0]     index_out,
    output logic [posl_pkg::FLD_CNT_W-1:0]     count,
    output logic [1:0]                         status,
    output logic                               last
);

    posl_pkg::cmd_t       push_cmd;
    posl_pkg::cmd_t       head;
    posl_pkg::q_status_t  q_stat;
    logic                 push;
    logic                 pop;

    posl_front u_front (
        .start    (start),
        .q_full   (q_stat.full),
        .opcode   (opcode),
        .value    (value),
        .position (position),
        .busy     (busy),
        .push     (push),
        .cmd      (push_cmd)
    );

    posl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    posl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .valid     (valid),
        .value_out (value_out),
        .index_out (index_out),
        .count     (count),
        .status    (status),
        .last      (last)
    );

endmodule

`default_nettype wire
